FILE: hdl/csma_tx_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and widths for the CSMA MAC transmit controller.
// No dependencies; used by every module under hdl/ except csma_tx_skid.

package csma_tx_pkg;

    // Default sizing handed to the top-level parameters
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int PACKET_BITS_DEF = 32;

    // Fixed field widths
    localparam int KIND_W    = 2;
    localparam int FILL_W    = 5;
    localparam int BACKOFF_W = 8;
    localparam int WAIT_W    = 16;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [FILL_W-1:0]    QUEUE_LIMIT_RST  = 5'd16;
    localparam logic [BACKOFF_W-1:0] MAX_BACKOFFS_RST = 8'd4;
    localparam logic [WAIT_W-1:0]    BACKOFF_WAIT_RST = 16'd100;

    localparam logic [BACKOFF_W-1:0] RETRY_MAX = '1;
    localparam logic [CNT_W-1:0]     CNT_MAX   = '1;

    typedef enum logic [KIND_W-1:0] {
        EV_ARRIVE  = 2'd0,
        EV_SENSE   = 2'd1,
        EV_CONFIRM = 2'd2,
        EV_EXPIRE  = 2'd3
    } event_kind_t;

    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_SENSE    = 2'd1,
        ACT_TRANSMIT = 2'd2,
        ACT_TIMER    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        MODE_IDLE         = 2'd0,
        MODE_WAIT_SENSE   = 2'd1,
        MODE_WAIT_TIMER   = 2'd2,
        MODE_WAIT_CONFIRM = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUEUE_LIMIT  = 2'd0,
        CFG_MAX_BACKOFFS = 2'd1,
        CFG_BACKOFF_WAIT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [FILL_W-1:0]    queue_limit;
        logic [BACKOFF_W-1:0] max_backoffs;
        logic [WAIT_W-1:0]    backoff_wait;
    } cfg_t;

    // Queue commands from the controller
    typedef struct packed {
        logic push;
        logic pop;
    } q_cmd_t;

    // Result fields of fixed width (the packet word travels separately)
    typedef struct packed {
        action_t           action;
        logic [WAIT_W-1:0] timer_wait;
        logic              dropped_full;
        logic              dropped_retries;
        logic [CNT_W-1:0]  full_drop_total;
        logic [CNT_W-1:0]  retry_drop_total;
        logic [FILL_W-1:0] queue_fill;
    } mac_result_t;

endpackage

FILE: hdl/csma_tx_queue.sv
`timescale 1ns / 1ps
// Packet FIFO: storage array, head/tail pointers, fill level, head-word read.
// Depends on csma_tx_pkg.

module csma_tx_queue #(
    parameter int QUEUE_DEPTH = csma_tx_pkg::QUEUE_DEPTH_DEF,
    parameter int PACKET_BITS = csma_tx_pkg::PACKET_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  csma_tx_pkg::q_cmd_t           cmd,
    input  logic [PACKET_BITS-1:0]        push_data,
    output logic [csma_tx_pkg::FILL_W-1:0] fill,
    output logic [csma_tx_pkg::FILL_W-1:0] fill_next,
    output logic [PACKET_BITS-1:0]        head_word
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [PACKET_BITS-1:0] mem [QUEUE_DEPTH];

    logic [IDX_W-1:0]               head_reg, head_next;
    logic [IDX_W-1:0]               tail_reg, tail_next;
    logic [csma_tx_pkg::FILL_W-1:0] fill_reg;
    logic [PACKET_BITS-1:0]         rd_data_reg;
    logic                           byp_hit_reg;
    logic [PACKET_BITS-1:0]         byp_data_reg;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] ptr);
        logic [IDX_W-1:0] res;
        if (ptr == IDX_W'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = ptr + 1'b1;
        end
        return res;
    endfunction

    // Pointer and level updates
    always_comb begin
        head_next = cmd.pop  ? wrap_inc(head_reg) : head_reg;
        tail_next = cmd.push ? wrap_inc(tail_reg) : tail_reg;
        if (cmd.push) begin
            fill_next = fill_reg + 1'b1;
        end else if (cmd.pop) begin
            fill_next = fill_reg - 1'b1;
        end else begin
            fill_next = fill_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    // Storage: write at tail, read the next head each cycle
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[tail_reg] <= push_data;
        end
        rd_data_reg <= mem[head_next];
    end

    // A push landing on the slot being read is forwarded
    always_ff @(posedge aclk) begin
        byp_hit_reg  <= cmd.push && (tail_reg == head_next);
        byp_data_reg <= push_data;
    end

    assign fill      = fill_reg;
    assign head_word = (fill_reg == '0) ? '0 :
                       (byp_hit_reg ? byp_data_reg : rd_data_reg);

endmodule

FILE: hdl/csma_tx_fsm.sv
`timescale 1ns / 1ps
// MAC mode machine, retry count and drop counters; builds one result per event.
// Depends on csma_tx_pkg.

module csma_tx_fsm #(
    parameter int QUEUE_DEPTH = csma_tx_pkg::QUEUE_DEPTH_DEF,
    parameter int PACKET_BITS = csma_tx_pkg::PACKET_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           ev_valid,
    input  csma_tx_pkg::event_kind_t       ev_kind,
    input  logic                           channel_busy,
    input  logic                           confirm_ok,
    input  csma_tx_pkg::cfg_t              cfg,
    input  logic [csma_tx_pkg::FILL_W-1:0] fill,
    input  logic [csma_tx_pkg::FILL_W-1:0] fill_next,
    input  logic [PACKET_BITS-1:0]         head_word,
    output csma_tx_pkg::q_cmd_t            q_cmd,
    output csma_tx_pkg::mac_result_t       result,
    output logic [PACKET_BITS-1:0]         tx_packet,
    output csma_tx_pkg::mode_t             mode
);

    // Queue never holds more than the limit register can express
    localparam int FILL_MAX = (1 << csma_tx_pkg::FILL_W) - 1;
    localparam int CAP      = (QUEUE_DEPTH < FILL_MAX) ? QUEUE_DEPTH : FILL_MAX;

    csma_tx_pkg::mode_t mode_reg, mode_next, mode_ev;

    logic [csma_tx_pkg::BACKOFF_W-1:0] retry_reg, retry_next, retry_sat;
    logic [csma_tx_pkg::CNT_W-1:0]     full_drops_reg, full_drops_next;
    logic [csma_tx_pkg::CNT_W-1:0]     retry_drops_reg, retry_drops_next;
    logic [csma_tx_pkg::FILL_W-1:0]    limit;

    logic arrive, drop_full, push;
    logic ans_clear, ans_busy, give_up, backoff;
    logic confirm, expire, pop, start;

    // Event decode against the current mode
    assign limit = (cfg.queue_limit > csma_tx_pkg::FILL_W'(CAP)) ?
                   csma_tx_pkg::FILL_W'(CAP) : cfg.queue_limit;

    assign arrive    = ev_valid && (ev_kind == csma_tx_pkg::EV_ARRIVE);
    assign drop_full = arrive && (fill >= limit);
    assign push      = arrive && !(fill >= limit);

    assign ans_clear = ev_valid && (ev_kind == csma_tx_pkg::EV_SENSE) &&
                       (mode_reg == csma_tx_pkg::MODE_WAIT_SENSE) && !channel_busy;
    assign ans_busy  = ev_valid && (ev_kind == csma_tx_pkg::EV_SENSE) &&
                       (mode_reg == csma_tx_pkg::MODE_WAIT_SENSE) && channel_busy;
    assign retry_sat = (retry_reg == csma_tx_pkg::RETRY_MAX) ? retry_reg : retry_reg + 1'b1;
    assign give_up   = ans_busy && (retry_sat >= cfg.max_backoffs);
    assign backoff   = ans_busy && !(retry_sat >= cfg.max_backoffs);

    assign confirm = ev_valid && (ev_kind == csma_tx_pkg::EV_CONFIRM) &&
                     (mode_reg == csma_tx_pkg::MODE_WAIT_CONFIRM);
    assign expire  = ev_valid && (ev_kind == csma_tx_pkg::EV_EXPIRE) &&
                     (mode_reg == csma_tx_pkg::MODE_WAIT_TIMER);

    assign pop = (give_up || (confirm && confirm_ok)) && (fill != '0);

    assign q_cmd.push = push;
    assign q_cmd.pop  = pop;

    // Next state: event transition, then idle start if packets remain
    always_comb begin
        mode_ev = mode_reg;
        if (ans_clear) begin
            mode_ev = csma_tx_pkg::MODE_WAIT_CONFIRM;
        end else if (backoff) begin
            mode_ev = csma_tx_pkg::MODE_WAIT_TIMER;
        end else if (give_up || confirm) begin
            mode_ev = csma_tx_pkg::MODE_IDLE;
        end else if (expire) begin
            mode_ev = csma_tx_pkg::MODE_WAIT_SENSE;
        end
        start     = ev_valid && (mode_ev == csma_tx_pkg::MODE_IDLE) && (fill_next != '0);
        mode_next = start ? csma_tx_pkg::MODE_WAIT_SENSE : mode_ev;
    end

    // Retry count and saturating drop counters
    always_comb begin
        if (start) begin
            retry_next = '0;
        end else if (ans_busy) begin
            retry_next = retry_sat;
        end else begin
            retry_next = retry_reg;
        end
        full_drops_next  = (drop_full && (full_drops_reg != csma_tx_pkg::CNT_MAX)) ?
                           full_drops_reg + 1'b1 : full_drops_reg;
        retry_drops_next = (give_up && (retry_drops_reg != csma_tx_pkg::CNT_MAX)) ?
                           retry_drops_reg + 1'b1 : retry_drops_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= csma_tx_pkg::MODE_IDLE;
            retry_reg       <= '0;
            full_drops_reg  <= '0;
            retry_drops_reg <= '0;
        end else begin
            mode_reg        <= mode_next;
            retry_reg       <= retry_next;
            full_drops_reg  <= full_drops_next;
            retry_drops_reg <= retry_drops_next;
        end
    end

    // Outputs for this event
    always_comb begin
        if (start || expire) begin
            result.action = csma_tx_pkg::ACT_SENSE;
        end else if (ans_clear) begin
            result.action = csma_tx_pkg::ACT_TRANSMIT;
        end else if (backoff) begin
            result.action = csma_tx_pkg::ACT_TIMER;
        end else begin
            result.action = csma_tx_pkg::ACT_NONE;
        end
        result.timer_wait       = backoff ? cfg.backoff_wait : '0;
        result.dropped_full     = drop_full;
        result.dropped_retries  = give_up;
        result.full_drop_total  = full_drops_next;
        result.retry_drop_total = retry_drops_next;
        result.queue_fill       = fill_next;
        tx_packet               = ans_clear ? head_word : '0;
    end

    assign mode = mode_reg;

endmodule

FILE: hdl/csma_tx_skid.sv
`timescale 1ns / 1ps
// Output register with a skid stage so the input ready is a flop.
// No dependencies; csma_tx_pkg is not used here.

module csma_tx_skid #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic              out_valid_reg, skid_valid_reg;
    logic [DATA_W-1:0] out_data_reg, skid_data_reg;
    logic              in_xfer, out_free;

    assign in_ready = !skid_valid_reg;
    assign in_xfer  = in_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || out_ready;

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg  <= skid_valid_reg || in_xfer;
            skid_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_xfer) begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: hdl/csma_mac_tx_controller_unit.sv
`timescale 1ns / 1ps
// Each result is registered onto m_, held in the skid stage first while m_ stalls.
// Throughput: one event per cycle; s_tready drops only while both the output
// register and the skid stage hold results, set by the two-entry output buffer.
// Reset (aresetn low, synchronous) clears mode, retry count, queue pointers,
// drop counters and output valids, and loads the register defaults; the packet
// store is not cleared.

module csma_mac_tx_controller_unit #(
    parameter int QUEUE_DEPTH = csma_tx_pkg::QUEUE_DEPTH_DEF,
    parameter int PACKET_BITS = csma_tx_pkg::PACKET_BITS_DEF,
    localparam int S_TDATA_W  = ((PACKET_BITS + 2 + 7) / 8) * 8,
    localparam int M_FIELDS_W = PACKET_BITS + csma_tx_pkg::WAIT_W + 2
                                + 2 * csma_tx_pkg::CNT_W + csma_tx_pkg::FILL_W,
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port
    input  logic                               cfg_we,
    input  logic [csma_tx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [csma_tx_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Event stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [S_TDATA_W-1:0]               s_tdata,  // packet_word, channel_busy, confirm_ok
    input  logic [csma_tx_pkg::KIND_W-1:0]     s_tuser,  // event_kind
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [M_TDATA_W-1:0]               m_tdata,  // tx_packet, timer_wait, dropped_full,
                                                         // dropped_retries, full_drop_total,
                                                         // retry_drop_total, queue_fill
    output logic [1:0]                         m_tuser   // action
);

    localparam int SKID_W = 2 + M_TDATA_W;

    csma_tx_pkg::cfg_t        cfg_reg;
    csma_tx_pkg::q_cmd_t      q_cmd;
    csma_tx_pkg::mac_result_t result;
    csma_tx_pkg::mode_t       mode;

    logic                           ev_xfer;
    logic [PACKET_BITS-1:0]         packet_word, head_word, tx_packet;
    logic [csma_tx_pkg::FILL_W-1:0] fill, fill_next;
    logic [M_TDATA_W-1:0]           m_pack;
    logic [SKID_W-1:0]              skid_out;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.queue_limit  <= csma_tx_pkg::QUEUE_LIMIT_RST;
            cfg_reg.max_backoffs <= csma_tx_pkg::MAX_BACKOFFS_RST;
            cfg_reg.backoff_wait <= csma_tx_pkg::BACKOFF_WAIT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                csma_tx_pkg::CFG_QUEUE_LIMIT:
                    cfg_reg.queue_limit <= cfg_wdata[csma_tx_pkg::FILL_W-1:0];
                csma_tx_pkg::CFG_MAX_BACKOFFS:
                    cfg_reg.max_backoffs <= cfg_wdata[csma_tx_pkg::BACKOFF_W-1:0];
                csma_tx_pkg::CFG_BACKOFF_WAIT:
                    cfg_reg.backoff_wait <= cfg_wdata[csma_tx_pkg::WAIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Event transfer
    assign ev_xfer     = s_tvalid && s_tready;
    assign packet_word = s_tdata[PACKET_BITS-1:0];

    csma_tx_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PACKET_BITS (PACKET_BITS)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (q_cmd),
        .push_data (packet_word),
        .fill      (fill),
        .fill_next (fill_next),
        .head_word (head_word)
    );

    csma_tx_fsm #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PACKET_BITS (PACKET_BITS)
    ) u_fsm (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ev_valid     (ev_xfer),
        .ev_kind      (csma_tx_pkg::event_kind_t'(s_tuser)),
        .channel_busy (s_tdata[PACKET_BITS]),
        .confirm_ok   (s_tdata[PACKET_BITS+1]),
        .cfg          (cfg_reg),
        .fill         (fill),
        .fill_next    (fill_next),
        .head_word    (head_word),
        .q_cmd        (q_cmd),
        .result       (result),
        .tx_packet    (tx_packet),
        .mode         (mode)
    );

    // Pack result fields, lowest first, zero padded
    assign m_pack = M_TDATA_W'({result.queue_fill, result.retry_drop_total,
                                result.full_drop_total, result.dropped_retries,
                                result.dropped_full, result.timer_wait, tx_packet});

    csma_tx_skid #(
        .DATA_W (SKID_W)
    ) u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ev_xfer),
        .in_ready  (s_tready),
        .in_data   ({result.action, m_pack}),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (skid_out)
    );

    assign m_tdata = skid_out[M_TDATA_W-1:0];
    assign m_tuser = skid_out[SKID_W-1 -: 2];

    // An idle MAC always has an empty queue, and a waiting MAC a nonempty one
    a_mode_fill : assert property (@(posedge aclk) disable iff (!aresetn)
        (mode == csma_tx_pkg::MODE_IDLE) == (fill == '0))
        else $error("MAC mode and queue fill disagree");

    // A transmit request always has a queued packet behind it
    a_tx_queued : assert property (@(posedge aclk) disable iff (!aresetn)
        ev_xfer && (result.action == csma_tx_pkg::ACT_TRANSMIT) |-> (fill != '0))
        else $error("transmit request with empty queue");

    // Input stalls only while the output holds a result
    a_stall_cause : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

    // Push and pop never coincide
    a_push_pop : assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_cmd.push && q_cmd.pop))
        else $error("queue push and pop in the same event");

endmodule

FILE: verif/csma_mac_tx_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the CSMA MAC transmit controller: watches the config port and both
// streams, predicts every result and compares it field by field. Depends on csma_tx_pkg.

module csma_mac_tx_checker #(
    parameter int S_W = 40,
    parameter int M_W = 120
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [csma_tx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [csma_tx_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [S_W-1:0]                     s_tdata,   // packet_word, channel_busy,
                                                          // confirm_ok
    input  logic [csma_tx_pkg::KIND_W-1:0]     s_tuser,   // event_kind
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [M_W-1:0]                     m_tdata,   // tx_packet, timer_wait,
                                                          // dropped_full, dropped_retries,
                                                          // full_drop_total,
                                                          // retry_drop_total, queue_fill
    input  logic [1:0]                         m_tuser,   // action
    output int                                 fail_count,
    output int                                 pending_count,
    output csma_tx_pkg::mode_t                 mode_now
);

    typedef struct {
        csma_tx_pkg::action_t                action;
        logic [31:0]                         tx_packet;
        logic [csma_tx_pkg::WAIT_W-1:0]      timer_wait;
        logic                                dropped_full;
        logic                                dropped_retries;
        logic [csma_tx_pkg::CNT_W-1:0]       full_total;
        logic [csma_tx_pkg::CNT_W-1:0]       retry_total;
        logic [csma_tx_pkg::FILL_W-1:0]      fill;
    } mac_outcome_t;

    mac_outcome_t outcome_q[$];

    // Shadow registers
    logic [csma_tx_pkg::FILL_W-1:0]    limit_reg;
    logic [csma_tx_pkg::BACKOFF_W-1:0] backoffs_reg;
    logic [csma_tx_pkg::WAIT_W-1:0]    wait_reg;

    // Shadow MAC state
    csma_tx_pkg::mode_t                mac_mode;
    logic [csma_tx_pkg::BACKOFF_W-1:0] retries;
    logic [31:0]                       pkt_ring [16];
    logic [3:0]                        head_ptr;
    logic [3:0]                        tail_ptr;
    logic [csma_tx_pkg::FILL_W-1:0]    fill_lvl;
    logic [csma_tx_pkg::CNT_W-1:0]     full_drops;
    logic [csma_tx_pkg::CNT_W-1:0]     retry_drops;

    int failures = 0;
    int pending  = 0;

    assign fail_count    = failures;
    assign pending_count = pending;
    assign mode_now      = mac_mode;

    // Removes the head packet, if any
    task automatic drop_head_packet();
        if (fill_lvl != '0) begin
            head_ptr = head_ptr + 4'd1;
            fill_lvl = fill_lvl - 5'd1;
        end
    endtask

    // Applies one event to the shadow state and returns the result it produces
    task automatic compute_mac_outcome(input csma_tx_pkg::event_kind_t kind,
                                       input logic [31:0] word,
                                       input logic busy, input logic ok,
                                       output mac_outcome_t res);
        logic [csma_tx_pkg::FILL_W-1:0] limit;
        limit = (limit_reg < 5'd16) ? limit_reg : 5'd16;
        res.action          = csma_tx_pkg::ACT_NONE;
        res.tx_packet       = '0;
        res.timer_wait      = '0;
        res.dropped_full    = 1'b0;
        res.dropped_retries = 1'b0;

        case (kind)
            csma_tx_pkg::EV_ARRIVE: begin
                if (fill_lvl >= limit) begin
                    res.dropped_full = 1'b1;
                    if (full_drops != csma_tx_pkg::CNT_MAX) full_drops = full_drops + 1;
                end else begin
                    pkt_ring[tail_ptr] = word;
                    tail_ptr = tail_ptr + 4'd1;
                    fill_lvl = fill_lvl + 5'd1;
                end
            end
            csma_tx_pkg::EV_SENSE: begin
                if (mac_mode == csma_tx_pkg::MODE_WAIT_SENSE) begin
                    if (!busy) begin
                        res.action    = csma_tx_pkg::ACT_TRANSMIT;
                        res.tx_packet = (fill_lvl != '0) ? pkt_ring[head_ptr] : '0;
                        mac_mode      = csma_tx_pkg::MODE_WAIT_CONFIRM;
                    end else begin
                        if (retries != csma_tx_pkg::RETRY_MAX) retries = retries + 8'd1;
                        if (retries < backoffs_reg) begin
                            res.action     = csma_tx_pkg::ACT_TIMER;
                            res.timer_wait = wait_reg;
                            mac_mode       = csma_tx_pkg::MODE_WAIT_TIMER;
                        end else begin
                            drop_head_packet();
                            res.dropped_retries = 1'b1;
                            if (retry_drops != csma_tx_pkg::CNT_MAX) begin
                                retry_drops = retry_drops + 1;
                            end
                            mac_mode = csma_tx_pkg::MODE_IDLE;
                        end
                    end
                end
            end
            csma_tx_pkg::EV_CONFIRM: begin
                if (mac_mode == csma_tx_pkg::MODE_WAIT_CONFIRM) begin
                    if (ok) drop_head_packet();
                    mac_mode = csma_tx_pkg::MODE_IDLE;
                end
            end
            default: begin
                if (mac_mode == csma_tx_pkg::MODE_WAIT_TIMER) begin
                    res.action = csma_tx_pkg::ACT_SENSE;
                    mac_mode   = csma_tx_pkg::MODE_WAIT_SENSE;
                end
            end
        endcase

        // Idle MAC with work queued starts a fresh carrier sense
        if (mac_mode == csma_tx_pkg::MODE_IDLE && fill_lvl != '0) begin
            retries    = '0;
            res.action = csma_tx_pkg::ACT_SENSE;
            mac_mode   = csma_tx_pkg::MODE_WAIT_SENSE;
        end

        res.full_total  = full_drops;
        res.retry_total = retry_drops;
        res.fill        = fill_lvl;
    endtask

    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            failures++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, got_v);
        end
    endtask

    // Sample both channels and the config port at each rising edge
    always @(posedge aclk) begin : monitor
        mac_outcome_t exp_o;
        if (!aresetn) begin
            limit_reg    = csma_tx_pkg::QUEUE_LIMIT_RST;
            backoffs_reg = csma_tx_pkg::MAX_BACKOFFS_RST;
            wait_reg     = csma_tx_pkg::BACKOFF_WAIT_RST;
            mac_mode     = csma_tx_pkg::MODE_IDLE;
            retries      = '0;
            head_ptr     = '0;
            tail_ptr     = '0;
            fill_lvl     = '0;
            full_drops   = '0;
            retry_drops  = '0;
            outcome_q.delete();
        end else begin
            // Result transfer against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (outcome_q.size() == 0) begin
                    failures++;
                    $display("%0t: unexpected result, expected none, actual action %h tdata %h",
                             $time, m_tuser, m_tdata);
                end else begin
                    exp_o = outcome_q[0];
                    outcome_q.delete(0);
                    check_field("action", 32'(exp_o.action), 32'(m_tuser));
                    check_field("tx_packet", exp_o.tx_packet, m_tdata[31:0]);
                    check_field("timer_wait", 32'(exp_o.timer_wait), 32'(m_tdata[47:32]));
                    check_field("dropped_full", 32'(exp_o.dropped_full), 32'(m_tdata[48]));
                    check_field("dropped_retries", 32'(exp_o.dropped_retries),
                                32'(m_tdata[49]));
                    check_field("full_drop_total", exp_o.full_total, m_tdata[81:50]);
                    check_field("retry_drop_total", exp_o.retry_total, m_tdata[113:82]);
                    check_field("queue_fill", 32'(exp_o.fill), 32'(m_tdata[118:114]));
                end
            end

            // Register writes
            if (cfg_we) begin
                case (cfg_index)
                    csma_tx_pkg::CFG_QUEUE_LIMIT:
                        limit_reg = cfg_wdata[csma_tx_pkg::FILL_W-1:0];
                    csma_tx_pkg::CFG_MAX_BACKOFFS:
                        backoffs_reg = cfg_wdata[csma_tx_pkg::BACKOFF_W-1:0];
                    csma_tx_pkg::CFG_BACKOFF_WAIT:
                        wait_reg = cfg_wdata[csma_tx_pkg::WAIT_W-1:0];
                    default: ;
                endcase
            end

            // Event transfer
            if (s_tvalid && s_tready) begin
                compute_mac_outcome(csma_tx_pkg::event_kind_t'(s_tuser), s_tdata[31:0],
                                    s_tdata[32], s_tdata[33], exp_o);
                outcome_q.insert(outcome_q.size(), exp_o);
            end
        end
        pending = outcome_q.size();
    end

endmodule

FILE: verif/csma_mac_tx_controller_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for csma_mac_tx_controller_unit: clock, reset, event stimulus,
// result-side back-pressure and verdict. Depends on csma_tx_pkg and csma_mac_tx_checker.

module csma_mac_tx_controller_unit_tb;

    localparam int S_W          = 40;
    localparam int M_W          = 120;
    localparam int LIMIT_CYCLES = 200000;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 212;
    localparam int HOLD_CYCLES  = 120;

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               cfg_we    = 1'b0;
    logic [csma_tx_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [csma_tx_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [S_W-1:0]                     s_tdata   = '0;
    logic [csma_tx_pkg::KIND_W-1:0]     s_tuser   = '0;
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [M_W-1:0]                     m_tdata;
    logic [1:0]                         m_tuser;

    int                 fail_count;
    int                 pending_count;
    csma_tx_pkg::mode_t mode_now;
    int                 cycle_count     = 0;
    int                 hold_req_count  = 0;
    int                 burst_left      = 0;

    // Per-phase register settings and traffic mix; a wait of -1 is drawn at random
    int ph_limit    [NUM_PHASES] = '{16, 1, 0, 31, 16, 2, 20, 5};
    int ph_backoffs [NUM_PHASES] = '{4, 1, 0, 255, 3, 2, 8, 6};
    int ph_wait     [NUM_PHASES] = '{100, 0, 65535, 23130, -1, -1, 65535, -1};
    int ph_arrive   [NUM_PHASES] = '{30, 40, 30, 35, 70, 40, 25, 35};
    int ph_busy     [NUM_PHASES] = '{50, 40, 60, 50, 40, 50, 70, 55};

    always #1 aclk = ~aclk;

    csma_mac_tx_controller_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    csma_mac_tx_checker #(.S_W(S_W), .M_W(M_W)) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .mode_now      (mode_now)
    );

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("csma_mac_tx_controller_unit_tb failed");
            $finish;
        end
    end

    // Result-side back-pressure: changing stall styles plus requested long hold-offs
    initial begin : receiver
        int style;
        int style_left;
        int hold_left;
        int holds_seen;
        style      = 0;
        style_left = 0;
        hold_left  = 0;
        holds_seen = 0;
        forever begin
            @(negedge aclk);
            if (hold_req_count != holds_seen) begin
                holds_seen = hold_req_count;
                hold_left  = HOLD_CYCLES;
            end
            if (style_left == 0) begin
                style      = $urandom_range(3);
                style_left = $urandom_range(200, 40);
            end
            style_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(1));
                    2: m_tready <= ($urandom_range(3) == 0);
                    default: m_tready <= style_left[0];
                endcase
            end
        end
    end

    // Offers one event and holds it until the transfer; returns at a falling edge
    task automatic send_event(input csma_tx_pkg::event_kind_t kind, input logic [31:0] word,
                              input logic busy, input logic ok);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, ok, busy, word};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    initial begin : stimulus
        int                       phase;
        int                       counted;
        int                       pick;
        bit                       ignored;
        csma_tx_pkg::event_kind_t kind;
        logic [31:0]              word;
        logic                     busy;
        logic                     ok;

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: stray answers while idle, word extremes, every event kind,
        // busy confirm, backoff until the head packet is dropped
        send_event(csma_tx_pkg::EV_SENSE, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_event(csma_tx_pkg::EV_CONFIRM, 32'h0, 1'b0, 1'b1);
        send_event(csma_tx_pkg::EV_EXPIRE, 32'hA5A5_A5A5, 1'b1, 1'b0);
        send_event(csma_tx_pkg::EV_ARRIVE, 32'h0000_0000, 1'b1, 1'b1);
        send_event(csma_tx_pkg::EV_ARRIVE, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send_event(csma_tx_pkg::EV_EXPIRE, 32'h0, 1'b0, 1'b0);
        send_event(csma_tx_pkg::EV_CONFIRM, 32'h0, 1'b0, 1'b1);
        send_event(csma_tx_pkg::EV_SENSE, 32'h0, 1'b0, 1'b1);
        send_event(csma_tx_pkg::EV_SENSE, 32'h0, 1'b1, 1'b0);
        send_event(csma_tx_pkg::EV_CONFIRM, 32'h0, 1'b0, 1'b0);
        send_event(csma_tx_pkg::EV_SENSE, 32'h5555_5555, 1'b0, 1'b0);
        send_event(csma_tx_pkg::EV_CONFIRM, 32'h0, 1'b1, 1'b1);
        send_event(csma_tx_pkg::EV_SENSE, 32'h0, 1'b1, 1'b0);
        send_event(csma_tx_pkg::EV_SENSE, 32'h0, 1'b0, 1'b0);
        send_event(csma_tx_pkg::EV_EXPIRE, 32'h0, 1'b0, 1'b0);
        send_event(csma_tx_pkg::EV_SENSE, 32'h0, 1'b1, 1'b1);
        send_event(csma_tx_pkg::EV_EXPIRE, 32'h0, 1'b1, 1'b1);
        send_event(csma_tx_pkg::EV_SENSE, 32'h0, 1'b1, 1'b0);
        send_event(csma_tx_pkg::EV_EXPIRE, 32'h0, 1'b0, 1'b1);
        send_event(csma_tx_pkg::EV_SENSE, 32'h0, 1'b1, 1'b0);
        send_event(csma_tx_pkg::EV_ARRIVE, 32'h8000_0001, 1'b0, 1'b0);
        send_event(csma_tx_pkg::EV_SENSE, 32'h0, 1'b0, 1'b0);
        send_event(csma_tx_pkg::EV_CONFIRM, 32'h0, 1'b0, 1'b1);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            // Drain before touching the registers
            s_tvalid <= 1'b0;
            do @(negedge aclk); while (pending_count != 0);

            cfg_we    <= 1'b1;
            cfg_index <= csma_tx_pkg::CFG_QUEUE_LIMIT;
            cfg_wdata <= 16'(ph_limit[phase]);
            @(negedge aclk);
            cfg_index <= csma_tx_pkg::CFG_MAX_BACKOFFS;
            cfg_wdata <= 16'(ph_backoffs[phase]);
            @(negedge aclk);
            cfg_index <= csma_tx_pkg::CFG_BACKOFF_WAIT;
            cfg_wdata <= (ph_wait[phase] < 0) ? 16'($urandom) : 16'(ph_wait[phase]);
            @(negedge aclk);
            cfg_we <= 1'b0;

            if (phase == 1 || phase == 4) hold_req_count++;

            counted = 0;
            while (counted < PHASE_ITEMS) begin
                // Events the MAC awaits, arrivals at the phase's share, a little noise
                word = $urandom;
                busy = ($urandom_range(99) < ph_busy[phase]);
                ok   = ($urandom_range(99) < 70);
                pick = $urandom_range(99);
                if (pick < 10) begin
                    kind = csma_tx_pkg::event_kind_t'($urandom_range(3));
                    busy = 1'($urandom_range(1));
                    ok   = 1'($urandom_range(1));
                end else if (pick < 10 + ph_arrive[phase] ||
                             mode_now == csma_tx_pkg::MODE_IDLE) begin
                    kind = csma_tx_pkg::EV_ARRIVE;
                end else begin
                    case (mode_now)
                        csma_tx_pkg::MODE_WAIT_SENSE: kind = csma_tx_pkg::EV_SENSE;
                        csma_tx_pkg::MODE_WAIT_TIMER: kind = csma_tx_pkg::EV_EXPIRE;
                        default:                      kind = csma_tx_pkg::EV_CONFIRM;
                    endcase
                end
                ignored = (kind == csma_tx_pkg::EV_SENSE &&
                           mode_now != csma_tx_pkg::MODE_WAIT_SENSE)
                       || (kind == csma_tx_pkg::EV_CONFIRM &&
                           mode_now != csma_tx_pkg::MODE_WAIT_CONFIRM)
                       || (kind == csma_tx_pkg::EV_EXPIRE &&
                           mode_now != csma_tx_pkg::MODE_WAIT_TIMER);
                if (!ignored) counted++;
                send_event(kind, word, busy, ok);

                // Bursts separated by short gaps
                if (burst_left == 0) begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(8, 1)) @(negedge aclk);
                    burst_left = $urandom_range(40, 1);
                end else begin
                    burst_left--;
                end
            end
        end

        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_count != 0);
        repeat (8) @(negedge aclk);

        if (fail_count == 0) begin
            $display("csma_mac_tx_controller_unit_tb passed");
        end else begin
            $display("csma_mac_tx_controller_unit_tb failed");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/csma_tx_pkg.sv
hdl/csma_tx_queue.sv
hdl/csma_tx_fsm.sv
hdl/csma_tx_skid.sv
hdl/csma_mac_tx_controller_unit.sv
verif/csma_mac_tx_checker.sv
verif/csma_mac_tx_controller_unit_tb.sv
